>>> src/ue2ct_pkg.sv
//------------------------------------------------------------------------------
// ue2ct_pkg
// Shared types, stage indices and reciprocal constants for the epoch converter.
//------------------------------------------------------------------------------
`default_nettype none

package ue2ct_pkg;

   // Pipeline depth and stage indices.
   localparam int NUM_STAGES = 11;
   localparam int LAST_STAGE = NUM_STAGES - 1;

   localparam int ST_IN      = 0;   // day count product
   localparam int ST_SPLIT   = 1;   // day count and second of day
   localparam int ST_MIN_MUL = 2;   // minute count product, weekday product
   localparam int ST_MIN     = 3;   // minute count, second, weekday
   localparam int ST_TOD     = 4;   // hour and minute done
   localparam int ST_ERA_MUL = 2;   // shifted day count, era product
   localparam int ST_ERA     = 3;   // era and day of era
   localparam int ST_CENT    = 4;   // four-year and century corrections
   localparam int ST_YNUM    = 5;   // corrected day count for the year divide
   localparam int ST_YMUL    = 6;   // year of era product
   localparam int ST_YOE     = 7;   // year of era and day of year
   localparam int ST_MON     = 8;   // March-based month
   localparam int ST_DMUL    = 9;   // month start product
   localparam int ST_OUT     = 10;  // final date

   typedef logic [NUM_STAGES-1:0] stage_vec_type;
   localparam stage_vec_type STAGE_ALL = '1;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] weekday;
   } tod_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   // Calendar constants.
   localparam int SECS_PER_DAY   = 86400;
   localparam int MINS_PER_HOUR  = 60;
   localparam int SECS_PER_MIN   = 60;
   localparam int DAYS_PER_WEEK  = 7;
   localparam int WEEKDAY_ANCHOR = 4;
   localparam int DAYS_SHIFT     = 719468;
   localparam int DAYS_PER_ERA   = 146097;
   localparam int DAYS_LAST_ERA  = 146096;
   localparam int DAYS_PER_CENT  = 36524;
   localparam int DAYS_PER_4Y    = 1460;
   localparam int DAYS_PER_YEAR  = 365;
   localparam int YEARS_PER_CENT = 100;
   localparam int YEARS_PER_ERA  = 400;
   localparam int MONTH_SPAN     = 153;
   localparam int MONTH_STEP     = 5;
   localparam int MONTH_BIAS     = 2;
   localparam int MARCH_BASE     = 3;
   localparam int JAN_WRAP       = 10;
   localparam int LAST_FEB_MONTH = 2;

   // Division by a constant D for x < 2^W uses ceil(2^K / D) with 2^K >= 2^W * D,
   // which gives the exact floor without a correction step.
   localparam int DAY_PRESHIFT = 7;
   localparam int DAY_DIV      = 675;
   localparam int DAY_SHIFT    = 35;
   localparam logic [25:0] DAY_RECIP =
      26'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

   localparam int MIN_SHIFT = 23;
   localparam logic [17:0] MIN_RECIP =
      18'(((64'd1 << MIN_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

   localparam int HR_SHIFT = 17;
   localparam logic [11:0] HR_RECIP =
      12'(((64'd1 << HR_SHIFT) + 64'(MINS_PER_HOUR) - 64'd1) / 64'(MINS_PER_HOUR));

   localparam int WK_SHIFT = 20;
   localparam logic [17:0] WK_RECIP =
      18'(((64'd1 << WK_SHIFT) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));

   localparam int ERA_SHIFT = 38;
   localparam logic [20:0] ERA_RECIP =
      21'(((64'd1 << ERA_SHIFT) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));

   localparam int Q4Y_SHIFT = 29;
   localparam logic [18:0] Q4Y_RECIP =
      19'(((64'd1 << Q4Y_SHIFT) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y));

   localparam int YR_SHIFT = 27;
   localparam logic [18:0] YR_RECIP =
      19'(((64'd1 << YR_SHIFT) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

   localparam int C100_SHIFT = 16;
   localparam logic [9:0] C100_RECIP =
      10'(((64'd1 << C100_SHIFT) + 64'(YEARS_PER_CENT) - 64'd1) / 64'(YEARS_PER_CENT));

   localparam int MON_SHIFT = 20;
   localparam logic [12:0] MON_RECIP =
      13'(((64'd1 << MON_SHIFT) + 64'(MONTH_SPAN) - 64'd1) / 64'(MONTH_SPAN));

   localparam int DIV5_SHIFT = 15;
   localparam logic [12:0] DIV5_RECIP =
      13'(((64'd1 << DIV5_SHIFT) + 64'(MONTH_STEP) - 64'd1) / 64'(MONTH_STEP));

endpackage

`default_nettype wire

>>> src/ue2ct_split.sv
//------------------------------------------------------------------------------
// ue2ct_split
// Splits the epoch second count into a day count and a second of day.
//------------------------------------------------------------------------------
`default_nettype none

module ue2ct_split (
   input  wire                      clock,
   input  ue2ct_pkg::stage_vec_type adv,
   input  wire  [31:0]              epoch_seconds,
   output logic [15:0]              days,
   output logic [16:0]              sod
);
   import ue2ct_pkg::*;

   logic [31:0] secs_ff;
   logic [50:0] prod_ff;
   logic [50:0] prod_in;
   logic [15:0] days_ff;
   logic [15:0] days_in;
   logic [16:0] sod_ff;
   logic [31:0] sod_full;

   // The low seven bits of 86400 are zero, so the divide runs on secs / 128.
   assign prod_in = 51'(epoch_seconds[31:DAY_PRESHIFT]) * 51'(DAY_RECIP);

   assign days_in  = prod_ff[DAY_SHIFT +: 16];
   assign sod_full = secs_ff - 32'(days_in) * 32'(SECS_PER_DAY);

   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         secs_ff <= epoch_seconds;
         prod_ff <= prod_in;
      end
      if (adv[ST_SPLIT]) begin
         days_ff <= days_in;
         sod_ff  <= sod_full[16:0];
      end
   end

   assign days = days_ff;
   assign sod  = sod_ff;

endmodule

`default_nettype wire

>>> src/ue2ct_tod.sv
//------------------------------------------------------------------------------
// ue2ct_tod
// Hour, minute, second and weekday, delayed to line up with the date path.
//------------------------------------------------------------------------------
`default_nettype none

module ue2ct_tod (
   input  wire                      clock,
   input  ue2ct_pkg::stage_vec_type adv,
   input  wire  [15:0]              days,
   input  wire  [16:0]              sod,
   output ue2ct_pkg::tod_type       tod
);
   import ue2ct_pkg::*;

   logic [34:0] min_prod_ff;
   logic [16:0] sod2_ff;
   logic [34:0] wk_prod_ff;
   logic [16:0] wk_num_ff;
   logic [16:0] wk_num_in;

   logic [10:0] mt_in;
   logic [16:0] sec_full;
   logic [14:0] wk_q;
   logic [16:0] wd_full;
   logic [10:0] mt_ff;
   logic [5:0]  sec3_ff;
   logic [2:0]  wd3_ff;
   logic [22:0] hr_prod_ff;

   logic [4:0]  hour_in;
   logic [10:0] min_full;
   tod_type     tod_in;
   tod_type     tod_ff [ST_TOD:LAST_STAGE];

   assign wk_num_in = 17'(days) + 17'(WEEKDAY_ANCHOR);

   // Minute count and second of minute; the weekday remainder runs alongside.
   assign mt_in    = min_prod_ff[MIN_SHIFT +: 11];
   assign sec_full = sod2_ff - 17'(mt_in) * 17'(SECS_PER_MIN);
   assign wk_q     = wk_prod_ff[WK_SHIFT +: 15];
   assign wd_full  = wk_num_ff - 17'(wk_q) * 17'(DAYS_PER_WEEK);

   assign hour_in  = hr_prod_ff[HR_SHIFT +: 5];
   assign min_full = mt_ff - 11'(hour_in) * 11'(MINS_PER_HOUR);

   always_comb begin
      tod_in.hour    = hour_in;
      tod_in.minute  = min_full[5:0];
      tod_in.second  = sec3_ff;
      tod_in.weekday = wd3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_MIN_MUL]) begin
         min_prod_ff <= 35'(sod) * 35'(MIN_RECIP);
         sod2_ff     <= sod;
         wk_prod_ff  <= 35'(wk_num_in) * 35'(WK_RECIP);
         wk_num_ff   <= wk_num_in;
      end
      if (adv[ST_MIN]) begin
         mt_ff      <= mt_in;
         sec3_ff    <= sec_full[5:0];
         wd3_ff     <= wd_full[2:0];
         hr_prod_ff <= 23'(mt_in) * 23'(HR_RECIP);
      end
      if (adv[ST_TOD]) begin
         tod_ff[ST_TOD] <= tod_in;
      end
      for (int i = ST_TOD + 1; i <= LAST_STAGE; i++) begin
         if (adv[i]) begin
            tod_ff[i] <= tod_ff[i-1];
         end
      end
   end

   assign tod = tod_ff[LAST_STAGE];

endmodule

`default_nettype wire

>>> src/ue2ct_date.sv
//------------------------------------------------------------------------------
// ue2ct_date
// Proleptic Gregorian date from a day count, by era and day of era.
//------------------------------------------------------------------------------
`default_nettype none

module ue2ct_date (
   input  wire                      clock,
   input  ue2ct_pkg::stage_vec_type adv,
   input  wire  [15:0]              days,
   output ue2ct_pkg::date_type      date
);
   import ue2ct_pkg::*;

   // Era stage.
   logic [19:0] shifted_in;
   logic [19:0] shifted_ff;
   logic [40:0] era_prod_ff;
   logic [2:0]  era_in;
   logic [19:0] in_era_full;
   logic [2:0]  era3_ff;
   logic [17:0] in_era3_ff;

   // Four-year and century corrections.
   logic [2:0]  cent_in;
   logic [17:0] in_era4_ff;
   logic [36:0] q4y_prod_ff;
   logic [2:0]  cent4_ff;
   logic        last4_ff;
   logic [2:0]  era4_ff;

   logic [7:0]  q4y_in;
   logic [17:0] ynum_in;
   logic [17:0] ynum5_ff;
   logic [17:0] in_era5_ff;
   logic [2:0]  era5_ff;

   logic [36:0] yr_prod6_ff;
   logic [17:0] in_era6_ff;
   logic [2:0]  era6_ff;

   // Year of era and day of year.
   logic [8:0]  yoe_in;
   logic [18:0] c100_prod;
   logic [2:0]  c100_q;
   logic [17:0] year_start;
   logic [17:0] doy_full;
   logic [8:0]  yoe7_ff;
   logic [8:0]  doy7_ff;
   logic [2:0]  era7_ff;

   logic [11:0] mon_num;
   logic [24:0] mon_prod;
   logic [3:0]  mp8_ff;
   logic [8:0]  doy8_ff;
   logic [8:0]  yoe8_ff;
   logic [2:0]  era8_ff;

   logic [11:0] mstart_num;
   logic [24:0] mstart_prod9_ff;
   logic [3:0]  mp9_ff;
   logic [8:0]  doy9_ff;
   logic [8:0]  yoe9_ff;
   logic [2:0]  era9_ff;

   logic [9:0]  mstart_in;
   logic [9:0]  day_full;
   logic [3:0]  month_in;
   logic [11:0] year_in;
   date_type    date_in;
   date_type    date_ff;

   // Days are rebased to 0000-03-01 so leap days fall at the end of a year.
   assign shifted_in  = 20'(days) + 20'(DAYS_SHIFT);
   assign era_in      = era_prod_ff[ERA_SHIFT +: 3];
   assign in_era_full = shifted_ff - 20'(era_in) * 20'(DAYS_PER_ERA);

   always_comb begin
      cent_in = 3'd0;
      if (in_era3_ff >= 18'(DAYS_PER_CENT))     cent_in = 3'd1;
      if (in_era3_ff >= 18'(2 * DAYS_PER_CENT)) cent_in = 3'd2;
      if (in_era3_ff >= 18'(3 * DAYS_PER_CENT)) cent_in = 3'd3;
      if (in_era3_ff >= 18'(4 * DAYS_PER_CENT)) cent_in = 3'd4;
   end

   assign q4y_in  = q4y_prod_ff[Q4Y_SHIFT +: 8];
   assign ynum_in = in_era4_ff - 18'(q4y_in) + 18'(cent4_ff) - 18'(last4_ff);

   assign yoe_in     = yr_prod6_ff[YR_SHIFT +: 9];
   assign c100_prod  = 19'(yoe_in) * 19'(C100_RECIP);
   assign c100_q     = c100_prod[C100_SHIFT +: 3];
   assign year_start = 18'(yoe_in) * 18'(DAYS_PER_YEAR) + 18'(yoe_in[8:2]) - 18'(c100_q);
   assign doy_full   = in_era6_ff - year_start;

   assign mon_num  = 12'(doy7_ff) * 12'(MONTH_STEP) + 12'(MONTH_BIAS);
   assign mon_prod = 25'(mon_num) * 25'(MON_RECIP);

   assign mstart_num = 12'(mp8_ff) * 12'(MONTH_SPAN) + 12'(MONTH_BIAS);

   assign mstart_in = mstart_prod9_ff[DIV5_SHIFT +: 10];
   assign day_full  = 10'(doy9_ff) - mstart_in + 10'd1;
   assign month_in  = (mp9_ff < 4'(JAN_WRAP)) ? mp9_ff + 4'(MARCH_BASE)
                                               : mp9_ff - 4'(JAN_WRAP - 1);
   assign year_in   = 12'(yoe9_ff) + 12'(era9_ff) * 12'(YEARS_PER_ERA)
                      + ((month_in <= 4'(LAST_FEB_MONTH)) ? 12'd1 : 12'd0);

   always_comb begin
      date_in.year  = year_in;
      date_in.month = month_in;
      date_in.day   = day_full[4:0];
   end

   always_ff @(posedge clock) begin
      if (adv[ST_ERA_MUL]) begin
         shifted_ff  <= shifted_in;
         era_prod_ff <= 41'(shifted_in) * 41'(ERA_RECIP);
      end
      if (adv[ST_ERA]) begin
         era3_ff    <= era_in;
         in_era3_ff <= in_era_full[17:0];
      end
      if (adv[ST_CENT]) begin
         in_era4_ff  <= in_era3_ff;
         q4y_prod_ff <= 37'(in_era3_ff) * 37'(Q4Y_RECIP);
         cent4_ff    <= cent_in;
         last4_ff    <= (in_era3_ff == 18'(DAYS_LAST_ERA));
         era4_ff     <= era3_ff;
      end
      if (adv[ST_YNUM]) begin
         ynum5_ff   <= ynum_in;
         in_era5_ff <= in_era4_ff;
         era5_ff    <= era4_ff;
      end
      if (adv[ST_YMUL]) begin
         yr_prod6_ff <= 37'(ynum5_ff) * 37'(YR_RECIP);
         in_era6_ff  <= in_era5_ff;
         era6_ff     <= era5_ff;
      end
      if (adv[ST_YOE]) begin
         yoe7_ff <= yoe_in;
         doy7_ff <= doy_full[8:0];
         era7_ff <= era6_ff;
      end
      if (adv[ST_MON]) begin
         mp8_ff  <= mon_prod[MON_SHIFT +: 4];
         doy8_ff <= doy7_ff;
         yoe8_ff <= yoe7_ff;
         era8_ff <= era7_ff;
      end
      if (adv[ST_DMUL]) begin
         mstart_prod9_ff <= 25'(mstart_num) * 25'(DIV5_RECIP);
         mp9_ff          <= mp8_ff;
         doy9_ff         <= doy8_ff;
         yoe9_ff         <= yoe8_ff;
         era9_ff         <= era8_ff;
      end
      if (adv[ST_OUT]) begin
         date_ff <= date_in;
      end
   end

   assign date = date_ff;

endmodule

`default_nettype wire

>>> src/unix_epoch_to_civil_time.sv
//------------------------------------------------------------------------------
// unix_epoch_to_civil_time
// Unix second count to UTC calendar date, time of day and weekday.
//------------------------------------------------------------------------------
// Usage:
//   An item on the req_ channel carries a 32-bit unsigned count of seconds since
//   1970-01-01 00:00:00 UTC. For each item one result leaves on the rsp_ channel
//   with year, month, day, hour, minute, second and weekday (0 is Sunday).
//   The converter is an eleven-stage pipeline; every divide by a constant is a
//   multiply by a reciprocal with a register after it. An accepted item passes
//   every stage register before it reaches rsp_valid. While rsp_ready is high,
//   one item can be accepted in every cycle, so throughput is one per cycle.
//   Each stage keeps its own valid bit and loads whenever it is empty or its
//   item moves on, so when the receiver holds rsp_ready low the pipeline keeps
//   taking items until every stage is full; req_ready falls only then. The
//   result register holds its item steady until it is taken.
//   Reset clears all valid bits; the data registers are not reset, and no item
//   survives a reset.
//------------------------------------------------------------------------------
`default_nettype none

module unix_epoch_to_civil_time (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [2:0]  rsp_weekday
);
   import ue2ct_pkg::*;

   stage_vec_type vld_ff;
   stage_vec_type vld_in;
   stage_vec_type adv;

   logic [15:0] days;
   logic [16:0] sod;
   tod_type     tod;
   date_type    date;

   // A stage may load unless it and every stage after it hold an item that
   // cannot move on.
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         adv[i] = rsp_ready || !(&(vld_ff | ~(STAGE_ALL << i)));
      end
   end

   always_comb begin
      vld_in[ST_IN] = adv[ST_IN] ? req_valid : vld_ff[ST_IN];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   ue2ct_split u_split (
      .clock         (clock),
      .adv           (adv),
      .epoch_seconds (req_epoch_seconds),
      .days          (days),
      .sod           (sod)
   );

   ue2ct_tod u_tod (
      .clock (clock),
      .adv   (adv),
      .days  (days),
      .sod   (sod),
      .tod   (tod)
   );

   ue2ct_date u_date (
      .clock (clock),
      .adv   (adv),
      .days  (days),
      .date  (date)
   );

   assign req_ready   = adv[ST_IN];
   assign rsp_valid   = vld_ff[LAST_STAGE];
   assign rsp_year    = date.year;
   assign rsp_month   = date.month;
   assign rsp_day     = date.day;
   assign rsp_hour    = tod.hour;
   assign rsp_minute  = tod.minute;
   assign rsp_second  = tod.second;
   assign rsp_weekday = tod.weekday;

   // Input backpressure only appears with a full pipeline and a stalled receiver.
   a_ready_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&vld_ff) && !rsp_ready))
      else $error("req_ready low while the pipeline has room");

   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[ST_IN])
      else $error("accepted item missing from the first stage");

   a_date_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_year >= 12'd1970 && rsp_year <= 12'd2106
                     && rsp_month >= 4'd1 && rsp_month <= 4'd12
                     && rsp_day >= 5'd1 && rsp_day <= 5'd31))
      else $error("date field out of range");

   a_tod_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour < 5'd24 && rsp_minute < 6'd60
                     && rsp_second < 6'd60 && rsp_weekday < 3'd7))
      else $error("time of day or weekday out of range");

   a_drain_moves : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !vld_ff[LAST_STAGE-1]) |=> !rsp_valid)
      else $error("result repeated after it was taken");

endmodule

`default_nettype wire

>>> tb/civil_time_board_pkg.sv
//------------------------------------------------------------------------------
// civil_time_board_pkg
// Calendar predictor and result scoreboard for the epoch converter testbench.
// Each accepted timestamp is turned into the expected UTC date, time of day
// and weekday. The expectations are kept in order and compared field by field
// with the results that the converter hands back.
//------------------------------------------------------------------------------

package civil_time_board_pkg;

   import ue2ct_pkg::*;

   typedef struct packed {
      date_type date;
      tod_type  tod;
   } civil_time_type;

   typedef struct packed {
      logic [31:0]    stamp;
      civil_time_type civil;
   } pending_stamp_type;

   // Works in 32-bit unsigned arithmetic throughout. The day count is moved
   // to a calendar that starts on 0000-03-01, so that the leap day falls at
   // the end of each year, and then split into 400-year cycles.
   function automatic civil_time_type civil_from_seconds(logic [31:0] secs);
      civil_time_type civil;
      logic [31:0]    day_count;
      logic [31:0]    sec_of_day;
      logic [31:0]    shifted;
      logic [31:0]    cycle;
      logic [31:0]    day_of_cycle;
      logic [31:0]    year_of_cycle;
      logic [31:0]    day_of_year;
      logic [31:0]    march_month;
      logic [31:0]    month_num;
      logic [31:0]    day_num;
      logic [31:0]    year_num;
      day_count     = secs / 32'd86400;
      sec_of_day    = secs % 32'd86400;
      shifted       = day_count + 32'd719468;
      cycle         = shifted / 32'd146097;
      day_of_cycle  = shifted - cycle * 32'd146097;
      year_of_cycle = (day_of_cycle - day_of_cycle / 32'd1460 + day_of_cycle / 32'd36524
                       - day_of_cycle / 32'd146096) / 32'd365;
      day_of_year   = day_of_cycle - (32'd365 * year_of_cycle + year_of_cycle / 32'd4
                                      - year_of_cycle / 32'd100);
      march_month   = (32'd5 * day_of_year + 32'd2) / 32'd153;
      day_num       = day_of_year - (32'd153 * march_month + 32'd2) / 32'd5 + 32'd1;
      month_num     = (march_month < 32'd10) ? march_month + 32'd3 : march_month - 32'd9;
      year_num      = year_of_cycle + cycle * 32'd400 + ((month_num <= 32'd2) ? 32'd1 : 32'd0);
      civil.date.year    = year_num[11:0];
      civil.date.month   = month_num[3:0];
      civil.date.day     = day_num[4:0];
      civil.tod.hour     = 5'(sec_of_day / 32'd3600);
      civil.tod.minute   = 6'((sec_of_day % 32'd3600) / 32'd60);
      civil.tod.second   = 6'(sec_of_day % 32'd60);
      // 1970-01-01 was a Thursday.
      civil.tod.weekday  = 3'((day_count + 32'd4) % 32'd7);
      return civil;
   endfunction

   class civil_time_board;
      pending_stamp_type due_q[$];
      int unsigned       mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void note_stamp(logic [31:0] secs);
         pending_stamp_type entry;
         entry.stamp = secs;
         entry.civil = civil_from_seconds(secs);
         due_q.push_back(entry);
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction

      function void log_mismatch(string field, logic [31:0] stamp, logic [31:0] want,
                                 logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH stamp %0d %s: expected %0d actual %0d", stamp, field, want, got);
      endfunction

      function void check_result(civil_time_type got);
         pending_stamp_type want;
         if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH result with no item outstanding: %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                        got.date.year, got.date.month, got.date.day, got.tod.hour,
                        got.tod.minute, got.tod.second, got.tod.weekday);
            return;
         end
         want = due_q.pop_front();
         if (got.date.year !== want.civil.date.year)
            log_mismatch("year", want.stamp, 32'(want.civil.date.year),
                         32'(got.date.year));
         if (got.date.month !== want.civil.date.month)
            log_mismatch("month", want.stamp, 32'(want.civil.date.month),
                         32'(got.date.month));
         if (got.date.day !== want.civil.date.day)
            log_mismatch("day", want.stamp, 32'(want.civil.date.day),
                         32'(got.date.day));
         if (got.tod.hour !== want.civil.tod.hour)
            log_mismatch("hour", want.stamp, 32'(want.civil.tod.hour),
                         32'(got.tod.hour));
         if (got.tod.minute !== want.civil.tod.minute)
            log_mismatch("minute", want.stamp, 32'(want.civil.tod.minute),
                         32'(got.tod.minute));
         if (got.tod.second !== want.civil.tod.second)
            log_mismatch("second", want.stamp, 32'(want.civil.tod.second),
                         32'(got.tod.second));
         if (got.tod.weekday !== want.civil.tod.weekday)
            log_mismatch("weekday", want.stamp, 32'(want.civil.tod.weekday),
                         32'(got.tod.weekday));
      endfunction
   endclass

endpackage

>>> tb/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Checks the Unix epoch to UTC calendar converter against a calendar predictor.
// A directed set of timestamps covers the ends of the range, leap days, century
// years and day boundaries; random timestamps follow, biased toward day, year
// and February ends. Both handshake sides idle at random in phases, the result
// side holds off long enough to fill the pipeline, and the sender drains the
// block once before going on.
//------------------------------------------------------------------------------

module testbench;

   import ue2ct_pkg::*;
   import civil_time_board_pkg::*;

   localparam int unsigned RANDOM_PER_PHASE = 400;
   localparam int unsigned RSP_HOLD_CYCLES  = 60;
   localparam int unsigned WATCHDOG_LIMIT   = 2000;
   localparam int unsigned DIRECTED_COUNT   = 19;

   localparam logic [31:0] DIRECTED_STAMPS [DIRECTED_COUNT] = '{
      32'd0,          32'd1,          32'd59,         32'd3599,
      32'd3600,       32'd86399,      32'd86400,      32'd68169600,
      32'd946684799,  32'd951782400,  32'd951868800,  32'd2147483647,
      32'd2147483648, 32'd4107542399, 32'd4107542400, 32'h5555_5555,
      32'hAAAA_AAAA,  32'hFFFF_FFFE,  32'hFFFF_FFFF
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [2:0]  rsp_weekday;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served  = 0;
   int unsigned hold_left     = 0;

   civil_time_board board;

   unix_epoch_to_civil_time dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Days from 1970-01-01 to January 1 of the given year.
   function automatic int unsigned days_before_year(int unsigned yr);
      int unsigned prev;
      prev = yr - 1;
      return 365 * (yr - 1970) + (prev / 4 - 492) - (prev / 100 - 19) + (prev / 400 - 4);
   endfunction

   function automatic int unsigned leap_days(int unsigned yr);
      return ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 1 : 0;
   endfunction

   function automatic logic [31:0] pick_stamp();
      int unsigned    kind;
      int unsigned    yr;
      longint unsigned base;
      kind = $urandom_range(99);
      if (kind < 50)
         return $urandom();
      if (kind < 70) begin
         base = longint'($urandom_range(49709)) * 86400;
         return 32'(base + ($urandom_range(1) ? $urandom_range(2) : 86397 + $urandom_range(2)));
      end
      if (kind < 82) begin
         yr = $urandom_range(2106, 1971);
         return 32'(longint'(days_before_year(yr)) * 86400 - 3 + $urandom_range(5));
      end
      if (kind < 94) begin
         // Around the end of February, leap or not.
         yr = $urandom_range(2105, 1970);
         base = longint'(days_before_year(yr) + 59 + leap_days(yr)) * 86400;
         return 32'(base - 3 + $urandom_range(5));
      end
      if (kind < 97)
         return $urandom_range(300);
      return 32'hFFFF_FFFF - $urandom_range(300);
   endfunction

   task automatic offer_stamp(input logic [31:0] secs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (board.pending() != 0);
   endtask

   task automatic offer_random(input int unsigned count);
      for (int unsigned idx = 0; idx < count; idx++)
         offer_stamp(pick_stamp());
   endtask

   always @(posedge clock)
      if (!reset && req_valid && req_ready)
         board.note_stamp(req_epoch_seconds);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(civil_time_type'({rsp_year, rsp_month, rsp_day, rsp_hour,
                                              rsp_minute, rsp_second, rsp_weekday}));
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= RSP_HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 34;
      recv_idle_pct = 55;
      foreach (DIRECTED_STAMPS[idx])
         offer_stamp(DIRECTED_STAMPS[idx]);
      offer_random(RANDOM_PER_PHASE);

      // Let every outstanding item come back before the sides swap roles.
      drain_block();
      send_idle_pct = 55;
      recv_idle_pct = 34;
      offer_random(RANDOM_PER_PHASE);

      // Full rate; the long result stall makes the pipeline back up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests <= hold_requests + 1;
      offer_random(RANDOM_PER_PHASE);

      drain_block();
      repeat (NUM_STAGES + 4) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> filelist.f
src/ue2ct_pkg.sv
src/ue2ct_split.sv
src/ue2ct_tod.sv
src/ue2ct_date.sv
src/unix_epoch_to_civil_time.sv
tb/civil_time_board_pkg.sv
tb/testbench.sv
